// File: rtl/dq_pkg.sv
`default_nettype none

package dq_pkg;

    // Operation selector carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_BACK  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_BACK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ERR_OK        = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    localparam int unsigned VALUE_W = 32;

endpackage

`default_nettype wire

// File: rtl/dq_ram.sv
`default_nettype none

module dq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic                     re_b,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// File: rtl/double_ended_queue.sv
// Double-ended queue of 32-bit values held in a ring of DEPTH memory slots.
// Input channel s_*: s_tuser carries the operation (push front, push back,
// pop front, pop back), s_tdata the value to push; pops ignore s_tdata.
// Output channel m_*: one beat per operation with the error code, the count
// after the operation, an empty flag and the front and back values (zero
// when the queue is empty).
// A beat is taken in the idle state; the pointer and count update and any
// push write happen in that cycle. The next cycle reads the front and back
// slots from the two read ports of the slot memory, and the load step after
// it loads the result register and raises m_tvalid. Because the memory read
// is registered, an operation runs through idle, read and load states, and
// no new beat is taken until the state returns to idle.
// A push into a full queue drops the value and reports overflow; a pop from
// an empty queue leaves the state alone and reports underflow.
// Reset clears the head pointer and count; slot contents are not cleared.
// While m_tready stays low the finished result holds in the output register
// and the next operation waits in its load step until that beat leaves.
`default_nettype none

module double_ended_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // s_tdata: push_value[31:0]
    input  wire logic [31:0]         s_tdata,
    // s_tuser: func[1:0]
    input  wire logic [1:0]          s_tuser,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // m_tdata: error_code, entry_count, is_empty, front_value, back_value, zero fill
    output logic [((3 + $clog2(DEPTH + 1) + 2 * dq_pkg::VALUE_W + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned SW    = CW + 1;
    localparam int unsigned VW    = dq_pkg::VALUE_W;
    localparam int unsigned RAW_W = 2 + CW + 1 + 2 * VW;
    localparam int unsigned OUT_W = ((RAW_W + 7) / 8) * 8;

    dq_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  head_reg, head_next;
    logic [CW-1:0]  count_reg, count_next;
    dq_pkg::err_t   err_reg, err_next;
    logic           out_valid_reg, out_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic           rd_en;
    logic [AW-1:0]  back_addr;
    logic [VW-1:0]  front_rd, back_rd;
    logic [SW-1:0]  push_sum;
    logic [SW-1:0]  back_sum;
    logic           s_accept;
    logic           full;
    logic           empty;
    dq_pkg::func_t  func;

    assign s_tready = (state_reg == dq_pkg::S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign func  = dq_pkg::func_t'(s_tuser);
    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Slot for a back push: head + count, wrapped once
    always_comb
    begin
        push_sum = SW'(head_reg) + SW'(count_reg);
        if (push_sum >= SW'(DEPTH))
        begin
            push_sum = push_sum - SW'(DEPTH);
        end
    end

    // Slot of the back value after the operation
    always_comb
    begin
        back_sum = SW'(head_reg);
        if (!empty)
        begin
            back_sum = SW'(head_reg) + SW'(count_reg) - SW'(1);
        end
        if (back_sum >= SW'(DEPTH))
        begin
            back_sum = back_sum - SW'(DEPTH);
        end
        back_addr = back_sum[AW-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        waddr          = head_reg;
        rd_en          = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            dq_pkg::S_IDLE:
            begin
                if (s_accept)
                begin
                    err_next   = dq_pkg::ERR_OK;
                    state_next = dq_pkg::S_READ;
                    unique case (func)
                        dq_pkg::FUNC_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                err_next = dq_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                head_next  = (head_reg == '0) ? AW'(DEPTH - 1)
                                                              : head_reg - AW'(1);
                                we         = 1'b1;
                                waddr      = head_next;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dq_pkg::FUNC_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                err_next = dq_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = push_sum[AW-1:0];
                                count_next = count_reg + CW'(1);
                            end
                        end
                        dq_pkg::FUNC_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                err_next = dq_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                head_next  = (head_reg == AW'(DEPTH - 1)) ? '0
                                                                          : head_reg + AW'(1);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        dq_pkg::FUNC_POP_BACK:
                        begin
                            if (empty)
                            begin
                                err_next = dq_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            err_next = dq_pkg::ERR_OK;
                        end
                    endcase
                end
            end
            dq_pkg::S_READ:
            begin
                rd_en      = 1'b1;
                state_next = dq_pkg::S_LOAD;
            end
            dq_pkg::S_LOAD:
            begin
                // hold the result until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[1:0]          = err_reg;
                    out_data_next[2 +: CW]      = count_reg;
                    out_data_next[2 + CW]       = empty;
                    out_data_next[3 + CW +: VW] = empty ? '0 : front_rd;
                    out_data_next[3 + CW + VW +: VW] = empty ? '0 : back_rd;
                    state_next = dq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::S_IDLE;
            end
        endcase
    end

    dq_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (s_tdata),
        .re_a    (rd_en),
        .raddr_a (head_reg),
        .rdata_a (front_rd),
        .re_b    (rd_en),
        .raddr_b (back_addr),
        .rdata_b (back_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg < AW'(DEPTH - 1) || head_reg == AW'(DEPTH - 1))
        else $error("head pointer out of range");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> state_reg == dq_pkg::S_READ)
        else $error("accepted beat not followed by memory read");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2 + CW] == (m_tdata[2 +: CW] == '0)))
        else $error("empty flag disagrees with count");

    a_state_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dq_pkg::S_LOAD && out_valid_reg && !m_tready)
            |=> state_reg == dq_pkg::S_LOAD)
        else $error("result loaded over a stalled beat");

endmodule

`default_nettype wire
